/* src/bmidi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmidi_pkg
// Shared types, codes and helpers of the BLE-MIDI packet decoder.
// ----------------------------------------------------------------------------
package bmidi_pkg;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_HEADER     = 3'd1;
   localparam logic [2:0] ERR_SHORT      = 3'd2;
   localparam logic [2:0] ERR_TS_LAST    = 3'd3;
   localparam logic [2:0] ERR_STATUS     = 3'd4;
   localparam logic [2:0] ERR_INCOMPLETE = 3'd5;

   localparam logic [1:0] PH_WAIT      = 2'd0;
   localparam logic [1:0] PH_AFTER_HDR = 2'd1;
   localparam logic [1:0] PH_AFTER_TS  = 2'd2;
   localparam logic [1:0] PH_IN_PKT    = 2'd3;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [7:0] REALTIME    = 8'hF8;

   typedef struct packed {
      logic [7:0]  midi_byte;
      logic        message_end;
      logic        sysex_part;
      logic [12:0] timestamp_ms;
      logic [2:0]  error_code;
   } bmidi_result_type;

   typedef struct packed {
      logic [1:0]       count;
      bmidi_result_type first_res;
      bmidi_result_type second_res;
   } bmidi_batch_type;

   function automatic logic [1:0] msg_len(input logic [7:0] s);
      logic [1:0] len;
      len = 2'd0;
      if (s[7]) begin
         priority if (s < 8'hC0) len = 2'd3;
         else if (s < 8'hE0) len = 2'd2;
         else if (s < 8'hF0) len = 2'd3;
         else begin
            unique case (s[3:0])
               4'h1, 4'h3: len = 2'd2;
               4'h2:       len = 2'd3;
               4'h6, 4'h7, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: len = 2'd1;
               default:    len = 2'd0;
            endcase
         end
      end
      return len;
   endfunction

   function automatic bmidi_result_type make_result(input logic [7:0] b, input logic e,
                                                    input logic sx, input logic [12:0] ts);
      bmidi_result_type r;
      r.midi_byte    = b;
      r.message_end  = e;
      r.sysex_part   = sx;
      r.timestamp_ms = ts;
      r.error_code   = ERR_NONE;
      return r;
   endfunction

endpackage

/* src/bmidi_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmidi_parser
// Parse state and single-pass decode of one packet byte into up to two
// results.
// ----------------------------------------------------------------------------
module bmidi_parser import bmidi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      packet_byte,
   input  logic            packet_first,
   input  logic            packet_final,
   output bmidi_batch_type batch
);

   logic [5:0] ts_high_ff, ts_high_in;
   logic [6:0] ts_low_ff, ts_low_in;
   logic [7:0] running_ff, running_in;
   logic       restore_ff, restore_in;
   logic       sysex_ff, sysex_in;
   logic [1:0] left_ff, left_in;
   logic [1:0] phase_ff, phase_in;
   logic       seen_ff, seen_in;
   logic       drop_ff, drop_in;

   always_comb begin
      logic        fail;
      logic [2:0]  err;
      logic [1:0]  len;
      logic [12:0] ts;
      ts_high_in = ts_high_ff;
      ts_low_in  = ts_low_ff;
      running_in = running_ff;
      restore_in = restore_ff;
      sysex_in   = sysex_ff;
      left_in    = left_ff;
      phase_in   = phase_ff;
      seen_in    = seen_ff;
      drop_in    = drop_ff;
      fail       = 1'b0;
      err        = ERR_NONE;
      len        = 2'd0;
      ts         = {ts_high_ff, ts_low_ff};
      batch      = '0;

      if (packet_first) begin
         left_in = 2'd0;
         seen_in = 1'b0;
         drop_in = 1'b0;
         if (packet_byte[7:6] != 2'b10) begin
            fail = 1'b1;
            err  = ERR_HEADER;
         end else if (packet_final) begin
            fail = 1'b1;
            err  = ERR_SHORT;
         end else begin
            ts_high_in = packet_byte[5:0];
            ts_low_in  = 7'd0;
            phase_in   = PH_AFTER_HDR;
         end
      end else if (drop_ff) begin
         if (packet_final) begin
            drop_in  = 1'b0;
            phase_in = PH_WAIT;
         end
      end else if (phase_ff == PH_WAIT) begin
         phase_in = PH_WAIT;
      end else if (phase_ff == PH_AFTER_HDR && packet_final) begin
         fail = 1'b1;
         err  = ERR_SHORT;
      end else if (packet_byte[7] && phase_ff != PH_AFTER_TS) begin
         if (!sysex_ff && left_ff != 2'd0) begin
            fail = 1'b1;
            err  = ERR_INCOMPLETE;
         end else begin
            if (seen_ff && packet_byte[6:0] < ts_low_ff) begin
               ts_high_in = 6'(ts_high_ff + 6'd1);
            end
            ts_low_in = packet_byte[6:0];
            seen_in   = 1'b1;
            if (packet_final) begin
               fail = 1'b1;
               err  = ERR_TS_LAST;
            end else begin
               phase_in = PH_AFTER_TS;
            end
         end
      end else begin
         phase_in = PH_IN_PKT;
         if (packet_byte[7]) begin
            if (packet_byte >= REALTIME) begin
               if (msg_len(packet_byte) == 2'd0) begin
                  fail = 1'b1;
                  err  = ERR_STATUS;
               end else begin
                  batch.first_res = make_result(packet_byte, 1'b1, 1'b0, ts);
                  batch.count     = 2'd1;
               end
            end else if (packet_byte == SYSEX_START) begin
               sysex_in        = 1'b1;
               restore_in      = 1'b1;
               left_in         = 2'd0;
               batch.first_res = make_result(packet_byte, 1'b0, 1'b1, ts);
               batch.count     = 2'd1;
            end else if (packet_byte == SYSEX_END) begin
               sysex_in        = 1'b0;
               restore_in      = 1'b1;
               left_in         = 2'd0;
               batch.first_res = make_result(packet_byte, 1'b1, sysex_ff, ts);
               batch.count     = 2'd1;
            end else begin
               sysex_in = 1'b0;
               len      = msg_len(packet_byte);
               if (len == 2'd0) begin
                  fail = 1'b1;
                  err  = ERR_STATUS;
               end else begin
                  if (packet_byte < SYSEX_START) begin
                     running_in = packet_byte;
                     restore_in = 1'b0;
                  end else begin
                     restore_in = 1'b1;
                  end
                  left_in         = 2'(len - 2'd1);
                  batch.first_res = make_result(packet_byte, len == 2'd1, 1'b0, ts);
                  batch.count     = 2'd1;
               end
            end
         end else if (sysex_ff) begin
            batch.first_res = make_result(packet_byte, 1'b0, 1'b1, ts);
            batch.count     = 2'd1;
         end else if (left_ff != 2'd0) begin
            left_in         = 2'(left_ff - 2'd1);
            batch.first_res = make_result(packet_byte, left_ff == 2'd1, 1'b0, ts);
            batch.count     = 2'd1;
         end else begin
            len = msg_len(running_ff);
            if (len < 2'd2 || running_ff >= SYSEX_START) begin
               fail = 1'b1;
               err  = ERR_STATUS;
            end else begin
               left_in = 2'(len - 2'd2);
               if (restore_ff) begin
                  restore_in       = 1'b0;
                  batch.first_res  = make_result(running_ff, 1'b0, 1'b0, ts);
                  batch.second_res = make_result(packet_byte, len == 2'd2, 1'b0, ts);
                  batch.count      = 2'd2;
               end else begin
                  batch.first_res = make_result(packet_byte, len == 2'd2, 1'b0, ts);
                  batch.count     = 2'd1;
               end
            end
         end
         if (!fail && packet_final) begin
            phase_in = PH_WAIT;
            if (!sysex_in && left_in != 2'd0) begin
               restore_in = restore_ff;
               fail       = 1'b1;
               err        = ERR_INCOMPLETE;
            end
         end
      end

      if (fail) begin
         left_in                     = 2'd0;
         phase_in                    = PH_WAIT;
         drop_in                     = !packet_final;
         batch                       = '0;
         batch.count                 = 2'd1;
         batch.first_res.error_code  = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_high_ff <= '0;
         ts_low_ff  <= '0;
         running_ff <= '0;
         restore_ff <= 1'b0;
         sysex_ff   <= 1'b0;
         left_ff    <= '0;
         phase_ff   <= PH_WAIT;
         seen_ff    <= 1'b0;
         drop_ff    <= 1'b0;
      end else if (advance) begin
         ts_high_ff <= ts_high_in;
         ts_low_ff  <= ts_low_in;
         running_ff <= running_in;
         restore_ff <= restore_in;
         sysex_ff   <= sysex_in;
         left_ff    <= left_in;
         phase_ff   <= phase_in;
         seen_ff    <= seen_in;
         drop_ff    <= drop_in;
      end
   end

endmodule

/* src/bmidi_rsp_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmidi_rsp_buf
// Two-entry result register; drains one result per transaction.
// ----------------------------------------------------------------------------
module bmidi_rsp_buf import bmidi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bmidi_batch_type  batch,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bmidi_result_type rsp_data
);

   logic [1:0]       count_ff, count_in;
   bmidi_result_type slot0_ff, slot0_in;
   bmidi_result_type slot1_ff, slot1_in;
   logic             take;

   assign rsp_valid = count_ff != 2'd0;
   assign take      = rsp_valid && !rsp_stall;
   assign free      = count_ff == 2'd0 || (count_ff == 2'd1 && !rsp_stall);
   assign rsp_data  = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         count_in = batch.count;
         slot0_in = batch.first_res;
         slot1_in = batch.second_res;
      end else if (take) begin
         if (count_ff == 2'd2) begin
            count_in = 2'd1;
            slot0_in = slot1_ff;
         end else begin
            count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

/* src/ble_midi_packet_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_midi_packet_decoder
// BLE-MIDI packet bytes in, plain MIDI bytes with timestamps out.
// ----------------------------------------------------------------------------
// Input channel req_*: one packet byte per transaction, with header and
// last-byte marks. Output channel rsp_*: one MIDI byte or one error report
// per transaction. Both channels use valid/stall.
// A byte is held in the input register, decoded in one pass against the
// parser state and written to a two-entry result register. A byte gives
// zero, one or two results; two only when a running status byte is
// restored. A result passes the input register, then the result register.
// Throughput is one byte per cycle while the receiver does not stall; a
// byte with two results holds the next byte back, as the single output port
// drains the result register. A byte with no result still waits until the
// result register can load. When the receiver stalls, the result register
// holds and the input register fills, after which req_stall rises.
// Reset clears the parser state to waiting for a packet header and empties
// both registers.
// ----------------------------------------------------------------------------
module ble_midi_packet_decoder import bmidi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_packet_first,
   input  logic        req_packet_final,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_midi_byte,
   output logic        rsp_message_end,
   output logic        rsp_sysex_part,
   output logic [12:0] rsp_timestamp_ms,
   output logic [2:0]  rsp_error_code
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_first_ff;
   logic             in_final_ff;
   logic             accept;
   logic             advance;
   logic             buf_free;
   bmidi_batch_type  batch;
   bmidi_result_type rsp_data;

   assign advance   = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_packet_byte;
         in_first_ff <= req_packet_first;
         in_final_ff <= req_packet_final;
      end
   end

   bmidi_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .packet_byte  (in_byte_ff),
      .packet_first (in_first_ff),
      .packet_final (in_final_ff),
      .batch        (batch)
   );

   bmidi_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .batch     (batch),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_midi_byte    = rsp_data.midi_byte;
   assign rsp_message_end  = rsp_data.message_end;
   assign rsp_sysex_part   = rsp_data.sysex_part;
   assign rsp_timestamp_ms = rsp_data.timestamp_ms;
   assign rsp_error_code   = rsp_data.error_code;

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |->
         rsp_midi_byte == 8'd0 && !rsp_message_end && !rsp_sysex_part &&
         rsp_timestamp_ms == 13'd0)
      else $error("error result carries payload");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_INCOMPLETE)
      else $error("error code out of range");

   a_sysex_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sysex_part && rsp_message_end |-> rsp_midi_byte == SYSEX_END)
      else $error("sysex message ends on a byte other than F7");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("transaction pending after reset");

endmodule

/* sim/midi_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_decode_checker
// Watches both channels of the BLE-MIDI packet decoder, predicts the MIDI
// bytes and error reports that each accepted packet byte causes, and compares
// every result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module midi_decode_checker import bmidi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_packet_first,
   input  logic        req_packet_final,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_midi_byte,
   input  logic        rsp_message_end,
   input  logic        rsp_sysex_part,
   input  logic [12:0] rsp_timestamp_ms,
   input  logic [2:0]  rsp_error_code,
   output int          mismatch_count,
   output int          pending_count
);

   bmidi_result_type expected_midi[$];

   logic [5:0] ts_hi;
   logic [6:0] ts_lo;
   logic [7:0] run_status;
   logic       restore_pending;
   logic       sysex_open;
   logic       ts_seen;
   logic       skip_packet;
   logic [1:0] phase;
   int         data_left;

   function automatic int status_length(input logic [7:0] s);
      if (!s[7]) return 0;
      case (s[7:4])
         4'hC, 4'hD: return 2;
         4'hF: begin
            case (s)
               8'hF1, 8'hF3: return 2;
               8'hF2:        return 3;
               8'hF6, SYSEX_END, REALTIME, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: return 1;
               default:      return 0;
            endcase
         end
         default: return 3;
      endcase
   endfunction

   function automatic bmidi_result_type midi_out(input logic [7:0] b, input logic e,
                                                 input logic sx, input logic [12:0] ts);
      bmidi_result_type r;
      r.midi_byte    = b;
      r.message_end  = e;
      r.sysex_part   = sx;
      r.timestamp_ms = ts;
      r.error_code   = ERR_NONE;
      return r;
   endfunction

   task automatic decode_packet_byte(input logic [7:0] b, input logic first, input logic fin);
      bmidi_result_type batch[$];
      bmidi_result_type fail_res;
      logic [2:0]  err;
      logic [12:0] ts;
      logic        saved_restore;
      int          len;
      err = ERR_NONE;
      saved_restore = restore_pending;
      ts = {ts_hi, ts_lo};
      if (first) begin
         data_left = 0;
         ts_seen = 1'b0;
         skip_packet = 1'b0;
         if (b[7:6] != 2'b10) err = ERR_HEADER;
         else if (fin) err = ERR_SHORT;
         else begin
            ts_hi = b[5:0];
            ts_lo = 7'd0;
            phase = PH_AFTER_HDR;
         end
      end else if (skip_packet) begin
         if (fin) begin
            skip_packet = 1'b0;
            phase = PH_WAIT;
         end
      end else if (phase == PH_AFTER_HDR && fin) begin
         err = ERR_SHORT;
      end else if (phase != PH_WAIT) begin
         if (b[7] && phase != PH_AFTER_TS) begin
            if (!sysex_open && data_left != 0) err = ERR_INCOMPLETE;
            else begin
               if (ts_seen && b[6:0] < ts_lo) ts_hi = ts_hi + 6'd1;
               ts_lo = b[6:0];
               ts_seen = 1'b1;
               if (fin) err = ERR_TS_LAST;
               else phase = PH_AFTER_TS;
            end
         end else begin
            ts = {ts_hi, ts_lo};
            phase = PH_IN_PKT;
            if (b[7]) begin
               if (b >= REALTIME) begin
                  if (status_length(b) == 0) err = ERR_STATUS;
                  else batch.push_back(midi_out(b, 1'b1, 1'b0, ts));
               end else if (b == SYSEX_START) begin
                  sysex_open = 1'b1;
                  restore_pending = 1'b1;
                  data_left = 0;
                  batch.push_back(midi_out(b, 1'b0, 1'b1, ts));
               end else if (b == SYSEX_END) begin
                  batch.push_back(midi_out(b, 1'b1, sysex_open, ts));
                  sysex_open = 1'b0;
                  restore_pending = 1'b1;
                  data_left = 0;
               end else begin
                  sysex_open = 1'b0;
                  len = status_length(b);
                  if (len == 0) err = ERR_STATUS;
                  else begin
                     if (b < SYSEX_START) begin
                        run_status = b;
                        restore_pending = 1'b0;
                     end else begin
                        restore_pending = 1'b1;
                     end
                     data_left = len - 1;
                     batch.push_back(midi_out(b, data_left == 0, 1'b0, ts));
                  end
               end
            end else if (sysex_open) begin
               batch.push_back(midi_out(b, 1'b0, 1'b1, ts));
            end else if (data_left != 0) begin
               data_left--;
               batch.push_back(midi_out(b, data_left == 0, 1'b0, ts));
            end else begin
               len = status_length(run_status);
               if (len < 2 || run_status >= SYSEX_START) err = ERR_STATUS;
               else begin
                  if (restore_pending) begin
                     batch.push_back(midi_out(run_status, 1'b0, 1'b0, ts));
                     restore_pending = 1'b0;
                  end
                  data_left = len - 2;
                  batch.push_back(midi_out(b, data_left == 0, 1'b0, ts));
               end
            end
            if (err == ERR_NONE && fin) begin
               phase = PH_WAIT;
               if (!sysex_open && data_left != 0) begin
                  restore_pending = saved_restore;
                  err = ERR_INCOMPLETE;
               end
            end
         end
      end
      if (err != ERR_NONE) begin
         data_left = 0;
         phase = PH_WAIT;
         skip_packet = !fin;
         fail_res = '0;
         fail_res.error_code = err;
         expected_midi.push_back(fail_res);
      end else begin
         foreach (batch[i]) expected_midi.push_back(batch[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [12:0] want,
                              input logic [12:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      bmidi_result_type want;
      if (reset) begin
         ts_hi = '0;
         ts_lo = '0;
         run_status = '0;
         restore_pending = 1'b0;
         sysex_open = 1'b0;
         ts_seen = 1'b0;
         skip_packet = 1'b0;
         phase = PH_WAIT;
         data_left = 0;
         mismatch_count = 0;
         expected_midi.delete();
      end else begin
         if (req_valid && !req_stall)
            decode_packet_byte(req_packet_byte, req_packet_first, req_packet_final);
         if (rsp_valid && !rsp_stall) begin
            if (expected_midi.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual byte 0x%0h error %0d",
                        $time, rsp_midi_byte, rsp_error_code);
               mismatch_count++;
            end else begin
               want = expected_midi.pop_front();
               check_field("midi_byte", 13'(want.midi_byte), 13'(rsp_midi_byte));
               check_field("message_end", 13'(want.message_end), 13'(rsp_message_end));
               check_field("sysex_part", 13'(want.sysex_part), 13'(rsp_sysex_part));
               check_field("timestamp_ms", want.timestamp_ms, rsp_timestamp_ms);
               check_field("error_code", 13'(want.error_code), 13'(rsp_error_code));
            end
         end
      end
      pending_count = expected_midi.size();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives BLE-MIDI packets into the packet decoder: a short directed set of
// headers, timestamp wraps, running status, restore, SysEx and error cases,
// then random packets, mostly well formed, some broken, with random idling on
// both channels, one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module testbench;
   import bmidi_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_packet_byte;
   logic        req_packet_first;
   logic        req_packet_final;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_midi_byte;
   logic        rsp_message_end;
   logic        rsp_sysex_part;
   logic [12:0] rsp_timestamp_ms;
   logic [2:0]  rsp_error_code;
   int          mismatch_count;
   int          pending_count;

   logic [9:0]  packet_items[$];
   logic [6:0]  ts_gen;
   int          running_data_gen;
   bit          sysex_gen;
   int          items_sent;

   logic [7:0]  realtime_codes[6] = '{8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF};
   logic [7:0]  common_codes[4]   = '{8'hF1, 8'hF2, 8'hF3, 8'hF6};
   logic [7:0]  bad_codes[4]      = '{8'hF4, 8'hF5, 8'hF9, 8'hFD};

   ble_midi_packet_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_packet_byte  (req_packet_byte),
      .req_packet_first (req_packet_first),
      .req_packet_final (req_packet_final),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_midi_byte    (rsp_midi_byte),
      .rsp_message_end  (rsp_message_end),
      .rsp_sysex_part   (rsp_sysex_part),
      .rsp_timestamp_ms (rsp_timestamp_ms),
      .rsp_error_code   (rsp_error_code)
   );

   midi_decode_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_packet_byte  (req_packet_byte),
      .req_packet_first (req_packet_first),
      .req_packet_final (req_packet_final),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_midi_byte    (rsp_midi_byte),
      .rsp_message_end  (rsp_message_end),
      .rsp_sysex_part   (rsp_sysex_part),
      .rsp_timestamp_ms (rsp_timestamp_ms),
      .rsp_error_code   (rsp_error_code),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic add_item(input logic first, input logic fin, input logic [7:0] b);
      packet_items.push_back({first, fin, b});
   endtask

   task automatic add_data;
      add_item(1'b0, 1'b0, {1'b0, 7'($urandom)});
   endtask

   // advance the timestamp, wrapping now and then
   task automatic add_ts;
      if ($urandom_range(0, 7) == 0) ts_gen = 7'($urandom);
      else ts_gen = ts_gen + 7'($urandom_range(0, 20));
      add_item(1'b0, 1'b0, {1'b1, ts_gen});
   endtask

   task automatic add_message;
      int         kind;
      int         count;
      logic [7:0] s;
      kind = $urandom_range(0, 11);
      if ((kind == 3 || kind == 4) && running_data_gen == 0) kind = 0;
      case (kind)
         0, 1, 2, 10: begin
            s = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
            count = (s[6:5] == 2'b10) ? 1 : 2;
            running_data_gen = count;
            add_ts();
            add_item(1'b0, 1'b0, s);
            if (kind == 10) count = count - 1;
            repeat (count) add_data();
            sysex_gen = 1'b0;
         end
         3, 4: begin
            if (kind == 3) add_ts();
            repeat (running_data_gen) add_data();
         end
         5: begin
            s = common_codes[$urandom_range(0, 3)];
            add_ts();
            add_item(1'b0, 1'b0, s);
            if (s == 8'hF2) repeat (2) add_data();
            else if (s != 8'hF6) add_data();
            sysex_gen = 1'b0;
         end
         6: begin
            add_ts();
            add_item(1'b0, 1'b0, realtime_codes[$urandom_range(0, 5)]);
         end
         7: begin
            add_ts();
            add_item(1'b0, 1'b0, SYSEX_START);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 4) == 0) begin
                  add_ts();
                  add_item(1'b0, 1'b0, realtime_codes[$urandom_range(0, 5)]);
               end else begin
                  add_data();
               end
            end
            if ($urandom_range(0, 9) < 7) begin
               add_ts();
               add_item(1'b0, 1'b0, SYSEX_END);
               sysex_gen = 1'b0;
            end else begin
               sysex_gen = 1'b1;
            end
         end
         8: begin
            add_ts();
            add_item(1'b0, 1'b0, SYSEX_END);
         end
         9: begin
            add_ts();
            add_item(1'b0, 1'b0, bad_codes[$urandom_range(0, 3)]);
         end
         default: add_item(1'b0, 1'b0, 8'($urandom));
      endcase
   endtask

   task automatic build_packet;
      int         shape;
      logic [7:0] b;
      shape = $urandom_range(0, 19);
      if (shape == 1) begin
         b = 8'($urandom);
         if (b[7:6] == 2'b10) b[7] = 1'b0;
         if ($urandom_range(0, 1) == 0) begin
            add_item(1'b1, 1'b1, b);
         end else begin
            add_item(1'b1, 1'b0, b);
            repeat ($urandom_range(0, 3)) add_item(1'b0, 1'b0, 8'($urandom));
            add_item(1'b0, 1'b1, 8'($urandom));
         end
      end else if (shape == 2) begin
         add_item(1'b1, 1'b1, {2'b10, 6'($urandom)});
      end else if (shape == 3) begin
         add_item(1'b1, 1'b0, {2'b10, 6'($urandom)});
         add_item(1'b0, 1'b1, 8'($urandom));
      end else begin
         if (shape == 0) add_item(1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
         add_item(1'b1, 1'b0, {2'b10, 6'($urandom)});
         if (sysex_gen) begin
            repeat ($urandom_range(1, 4)) add_data();
            if ($urandom_range(0, 1) == 0) begin
               add_ts();
               add_item(1'b0, 1'b0, SYSEX_END);
               sysex_gen = 1'b0;
            end
         end
         repeat ($urandom_range(1, 5)) add_message();
         // cut the last byte off to leave a message short
         if (shape == 4 && packet_items.size() > 3) void'(packet_items.pop_back());
         packet_items[packet_items.size() - 1][8] = 1'b1;
      end
   endtask

   task automatic send_byte(input logic [9:0] item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_packet_first <= item[9];
      req_packet_final <= item[8];
      req_packet_byte <= item[7:0];
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_packet;
      bit burst;
      burst = ($urandom_range(0, 3) == 0);
      foreach (packet_items[i]) send_byte(packet_items[i], burst ? 0 : $urandom_range(0, 11));
      packet_items.delete();
   endtask

   initial begin
      int wait_n;
      int calm;
      bit hold_done;
      rsp_stall = 1'b0;
      calm = 0;
      hold_done = 1'b0;
      @(negedge clock);
      forever begin
         if (calm > 0) calm--;
         else if ($urandom_range(0, 7) == 0) calm = $urandom_range(10, 40);
         wait_n = (calm > 0) ? 0 : $urandom_range(0, 11);
         // hold off once for a long stretch so the input side backs up
         if (!hold_done && items_sent > 200) begin
            wait_n = wait_n + 400;
            hold_done = 1'b1;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      bit pause_done;
      reset = 1'b1;
      req_valid = 1'b0;
      req_packet_byte = 8'h00;
      req_packet_first = 1'b0;
      req_packet_final = 1'b0;
      ts_gen = 7'd0;
      running_data_gen = 0;
      sysex_gen = 1'b0;
      items_sent = 0;
      pause_done = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // byte outside any packet, then a bad header that is also final
      add_item(1'b0, 1'b0, 8'h90);
      add_item(1'b1, 1'b1, 8'h3C);
      // timestamp wrap, real-time, running status, restore after system common,
      // stray end of SysEx, timestamp as last byte
      add_item(1'b1, 1'b0, 8'hBF);
      add_item(1'b0, 1'b0, 8'hFF);
      add_item(1'b0, 1'b0, 8'h90);
      add_item(1'b0, 1'b0, 8'h7F);
      add_item(1'b0, 1'b0, 8'h00);
      add_item(1'b0, 1'b0, 8'h80);
      add_item(1'b0, 1'b0, 8'hF8);
      add_item(1'b0, 1'b0, 8'h12);
      add_item(1'b0, 1'b0, 8'h34);
      add_item(1'b0, 1'b0, 8'h81);
      add_item(1'b0, 1'b0, 8'hF1);
      add_item(1'b0, 1'b0, 8'h00);
      add_item(1'b0, 1'b0, 8'h56);
      add_item(1'b0, 1'b0, 8'h78);
      add_item(1'b0, 1'b0, 8'h82);
      add_item(1'b0, 1'b0, SYSEX_END);
      add_item(1'b0, 1'b1, 8'h83);
      // header alone, header then final byte
      add_item(1'b1, 1'b1, 8'h80);
      add_item(1'b1, 1'b0, 8'h80);
      add_item(1'b0, 1'b1, 8'h00);
      // SysEx data, then F5 after a data byte read as a timestamp, then final SysEx data
      add_item(1'b1, 1'b0, 8'h80);
      add_item(1'b0, 1'b0, 8'h80);
      add_item(1'b0, 1'b0, SYSEX_START);
      add_item(1'b0, 1'b0, 8'h7F);
      add_item(1'b0, 1'b0, 8'hF5);
      add_item(1'b0, 1'b1, 8'h00);
      send_packet();

      while (items_sent < 630) begin
         if (!pause_done && items_sent > 420) begin
            req_valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
            pause_done = 1'b1;
         end
         build_packet();
         send_packet();
      end
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
